>>> rtl/glzw_pkg.sv
// shared types, constants and helpers of the gif lzw encoder
package glzw_pkg;

   localparam int CODE_W          = 12;
   localparam int WIDTH_W         = 4;
   localparam int BUF_W           = 20;
   localparam int CNT_W           = 5;
   localparam int HASH_SIZE_DEF   = 5003;
   localparam int MAX_CODE_BITS_DEF = 12;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [CODE_W-1:0]  CLEAR_CODE  = 12'd256;
   localparam logic [CODE_W-1:0]  END_CODE    = 12'd257;
   localparam logic [CODE_W:0]    FIRST_FREE  = 13'd258;
   localparam logic [WIDTH_W-1:0] START_WIDTH = 4'd9;

   typedef struct packed {
      logic [7:0] pixel;
      logic       first_pixel;
      logic       last_pixel;
   } item_type;

   typedef enum logic [1:0] {
      CMD_PUT,
      CMD_RESTART,
      CMD_MARK,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [CODE_W-1:0]   code;
      logic [WIDTH_W-1:0]  width;
   } cmd_type;

   typedef struct packed {
      logic sweeping;
      logic probing;
   } core_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_READ,
      S_CMP,
      S_MISS,
      S_PUT_CLEAR,
      S_PUT_FINAL,
      S_PUT_END,
      S_FLUSH,
      S_MARK
   } core_state_type;

   typedef enum logic [1:0] {
      P_IDLE,
      P_EMIT,
      P_FLUSH,
      P_END
   } pack_state_type;

   function automatic int hash_shift(input int hs);
      int k;
      int f;
      k = 0;
      f = hs;
      while (f < 65536) begin
         f = f * 2;
         k = k + 1;
      end
      return (k >= 8) ? 0 : 8 - k;
   endfunction

endpackage

>>> rtl/glzw_front.sv
// input side: tracks the open image, drops stray pixels, feeds the queue
module glzw_front
   import glzw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic [7:0] req_tdata,
   input  logic     req_tlast,
   input  logic     req_tuser,
   output logic     push_valid,
   output item_type push_item,
   input  logic     push_ready
);

   logic open_ff, open_in;
   logic xfer;

   assign req_tready = push_ready;
   assign xfer       = req_tvalid && req_tready;
   assign push_valid = xfer && (req_tuser || open_ff);
   assign push_item  = '{pixel: req_tdata, first_pixel: req_tuser, last_pixel: req_tlast};

   always_comb begin
      open_in = open_ff;
      if (xfer && (req_tuser || open_ff)) begin
         open_in = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

endmodule

>>> rtl/glzw_queue.sv
// short item queue between the front and the dictionary engine
module glzw_queue
   import glzw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != QUEUE_DEPTH[PTR_W:0];
   assign pop_valid  = fill_ff != '0;
   assign pop_item   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + {{PTR_W{1'b0}}, do_push} - {{PTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

>>> rtl/glzw_core.sv
// dictionary engine: hash probing, table updates, code sequencing
module glzw_core
   import glzw_pkg::*;
#(
   parameter int HASH_SIZE     = HASH_SIZE_DEF,
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   input  item_type        pop_item,
   output logic            pop_ready,
   output logic            cmd_valid,
   output cmd_type         cmd,
   input  logic            cmd_ready,
   output core_status_type status
);

   localparam int IDX_W = $clog2(HASH_SIZE);
   localparam int KEY_W = 8 + MAX_CODE_BITS + 1;
   localparam int ENT_W = KEY_W + CODE_W;
   localparam int SHIFT = hash_shift(HASH_SIZE);
   localparam logic [IDX_W:0]   HS_EXT   = HASH_SIZE[IDX_W:0];
   localparam logic [IDX_W-1:0] HS_IDX   = HASH_SIZE[IDX_W-1:0];
   localparam logic [IDX_W-1:0] SWEEP_TOP = HS_IDX - 1'b1;
   localparam logic [CODE_W:0]  CODE_LIMIT = 13'd1 << MAX_CODE_BITS;
   localparam logic [WIDTH_W-1:0] MAX_W = MAX_CODE_BITS[WIDTH_W-1:0];

   logic [ENT_W-1:0] mem [HASH_SIZE];
   logic [ENT_W-1:0] rd_q;

   core_state_type     state_ff, state_in;
   logic [7:0]         pix_ff, pix_in;
   logic               last_ff, last_in;
   logic [CODE_W-1:0]  prefix_ff, prefix_in;
   logic [CODE_W:0]    nfc_ff, nfc_in;
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [CODE_W:0]    limit_ff, limit_in;
   logic               cp_ff, cp_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]   n_ff, n_in;
   logic               slot_ff, slot_in;
   logic               sweep_ff, sweep_in;
   logic [IDX_W-1:0]   sweep_addr_ff, sweep_addr_in;

   logic               ins_we;
   logic [KEY_W-1:0]   key;
   logic [IDX_W:0]     hraw;
   logic [IDX_W-1:0]   hidx;
   logic [IDX_W:0]     back;
   logic               put_done;

   function automatic logic [CODE_W:0] limit_for(input logic [WIDTH_W-1:0] w);
      if (w >= MAX_W) begin
         return CODE_LIMIT;
      end
      return (13'd1 << w) - 13'd1;
   endfunction

   assign key  = {1'b1, pix_ff, prefix_ff[MAX_CODE_BITS-1:0]};
   assign hraw = (IDX_W+1)'({pop_item.pixel, {SHIFT{1'b0}}}) ^ (IDX_W+1)'(prefix_ff);
   assign hidx = (hraw >= HS_EXT) ? IDX_W'(hraw - HS_EXT) : hraw[IDX_W-1:0];
   assign back = (idx_ff >= step_ff) ? {1'b0, idx_ff - step_ff}
                                     : {1'b0, idx_ff} + HS_EXT - {1'b0, step_ff};
   assign status = '{sweeping: sweep_ff, probing: state_ff == S_READ || state_ff == S_CMP};

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         mem[sweep_addr_ff] <= '0;
      end else if (ins_we) begin
         mem[idx_ff] <= {nfc_ff[CODE_W-1:0], key};
      end
      if (state_ff == S_READ) begin
         rd_q <= mem[idx_ff];
      end
   end

   always_comb begin
      state_in      = state_ff;
      pix_in        = pix_ff;
      last_in       = last_ff;
      prefix_in     = prefix_ff;
      nfc_in        = nfc_ff;
      width_in      = width_ff;
      limit_in      = limit_ff;
      cp_in         = cp_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      n_in          = n_ff;
      slot_in       = slot_ff;
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      ins_we        = 1'b0;
      pop_ready     = 1'b0;
      cmd_valid     = 1'b0;
      cmd           = '{kind: CMD_PUT, code: prefix_ff, width: width_ff};
      put_done      = 1'b0;

      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == SWEEP_TOP) begin
            sweep_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid && !sweep_ff) begin
               pop_ready = 1'b1;
               pix_in    = pop_item.pixel;
               last_in   = pop_item.last_pixel;
               if (pop_item.first_pixel) begin
                  nfc_in        = FIRST_FREE;
                  width_in      = START_WIDTH;
                  limit_in      = limit_for(START_WIDTH);
                  cp_in         = 1'b0;
                  sweep_in      = 1'b1;
                  sweep_addr_in = '0;
                  state_in      = S_FIRST;
               end else begin
                  idx_in   = hidx;
                  step_in  = (hidx == '0) ? IDX_W'(1) : HS_IDX - hidx;
                  n_in     = '0;
                  state_in = S_READ;
               end
            end
         end
         S_FIRST: begin
            cmd_valid = 1'b1;
            cmd       = '{kind: CMD_RESTART, code: CLEAR_CODE, width: width_ff};
            if (cmd_ready) begin
               put_done  = 1'b1;
               prefix_in = {4'd0, pix_ff};
               state_in  = last_ff ? S_PUT_FINAL : S_MARK;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (rd_q[KEY_W-1:0] == key) begin
               prefix_in = rd_q[ENT_W-1:KEY_W];
               state_in  = last_ff ? S_PUT_FINAL : S_MARK;
            end else if (rd_q[KEY_W-1:0] == '0) begin
               slot_in  = 1'b1;
               state_in = S_MISS;
            end else if (n_ff == HS_IDX) begin
               slot_in  = 1'b0;
               state_in = S_MISS;
            end else begin
               n_in     = n_ff + 1'b1;
               idx_in   = back[IDX_W-1:0];
               state_in = S_READ;
            end
         end
         S_MISS: begin
            cmd_valid = 1'b1;
            if (cmd_ready) begin
               put_done  = 1'b1;
               prefix_in = {4'd0, pix_ff};
               if (slot_ff && nfc_ff < CODE_LIMIT) begin
                  ins_we   = 1'b1;
                  nfc_in   = nfc_ff + 1'b1;
                  state_in = last_ff ? S_PUT_FINAL : S_MARK;
               end else begin
                  nfc_in        = FIRST_FREE;
                  sweep_in      = 1'b1;
                  sweep_addr_in = '0;
                  state_in      = S_PUT_CLEAR;
               end
            end
         end
         S_PUT_CLEAR: begin
            cmd_valid = 1'b1;
            cmd.code  = CLEAR_CODE;
            if (cmd_ready) begin
               put_done = 1'b1;
               state_in = last_ff ? S_PUT_FINAL : S_MARK;
            end
         end
         S_PUT_FINAL: begin
            cmd_valid = 1'b1;
            if (cmd_ready) begin
               put_done = 1'b1;
               state_in = S_PUT_END;
            end
         end
         S_PUT_END: begin
            cmd_valid = 1'b1;
            cmd.code  = END_CODE;
            if (cmd_ready) begin
               put_done = 1'b1;
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_FLUSH;
            if (cmd_ready) begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_MARK;
            if (cmd_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (put_done && (nfc_ff > limit_ff || cp_ff)) begin
         if (cp_ff) begin
            width_in = START_WIDTH;
            cp_in    = 1'b0;
            limit_in = limit_for(START_WIDTH);
         end else if (width_ff < MAX_W) begin
            width_in = width_ff + 1'b1;
            limit_in = limit_for(width_ff + 1'b1);
         end else begin
            limit_in = limit_for(width_ff);
         end
      end
      if (state_ff == S_MISS && cmd_ready && !(slot_ff && nfc_ff < CODE_LIMIT)) begin
         cp_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff    <= pix_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      step_ff   <= step_in;
      n_ff      <= n_in;
      slot_ff   <= slot_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         prefix_ff     <= '0;
         nfc_ff        <= FIRST_FREE;
         width_ff      <= START_WIDTH;
         limit_ff      <= limit_for(START_WIDTH);
         cp_ff         <= 1'b0;
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         prefix_ff     <= prefix_in;
         nfc_ff        <= nfc_in;
         width_ff      <= width_in;
         limit_ff      <= limit_in;
         cp_ff         <= cp_in;
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

endmodule

>>> rtl/glzw_packer.sv
// bit packer: codes in, lsb-first bytes out through hold and output registers
module glzw_packer
   import glzw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_ready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser
);

   pack_state_type   state_ff, state_in;
   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             end_ff, end_in;
   logic             hold_v_ff, hold_v_in;
   logic [7:0]       hold_ff, hold_in;
   logic             out_v_ff, out_v_in;
   logic [7:0]       out_ff, out_in;
   logic             out_last_ff, out_last_in;
   logic             out_end_ff, out_end_in;
   logic             out_free, can_put, produce;

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_end_ff;
   assign cmd_ready  = state_ff == P_IDLE;
   assign out_free   = !out_v_ff || rsp_tready;
   assign can_put    = !hold_v_ff || out_free;

   always_comb begin
      state_in    = state_ff;
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      end_in      = end_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_end_in  = out_end_ff;
      produce     = 1'b0;

      unique case (state_ff)
         P_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_PUT: begin
                     buf_in = (buf_ff & ~({BUF_W{1'b1}} << cnt_ff))
                              | ({{(BUF_W-CODE_W){1'b0}}, cmd.code} << cnt_ff);
                     cnt_in   = cnt_ff + {1'b0, cmd.width};
                     state_in = P_EMIT;
                  end
                  CMD_RESTART: begin
                     buf_in   = {{(BUF_W-CODE_W){1'b0}}, cmd.code};
                     cnt_in   = {1'b0, cmd.width};
                     state_in = P_EMIT;
                  end
                  CMD_MARK: begin
                     end_in   = 1'b0;
                     state_in = P_END;
                  end
                  CMD_FLUSH: begin
                     end_in   = 1'b1;
                     state_in = P_FLUSH;
                  end
                  default: begin
                     state_in = P_IDLE;
                  end
               endcase
            end
         end
         P_EMIT: begin
            if (cnt_ff >= CNT_W'(8)) begin
               if (can_put) begin
                  produce = 1'b1;
                  cnt_in  = cnt_ff - CNT_W'(8);
               end
            end else begin
               state_in = P_IDLE;
            end
         end
         P_FLUSH: begin
            if (cnt_ff != '0) begin
               if (can_put) begin
                  produce = 1'b1;
                  cnt_in  = (cnt_ff > CNT_W'(8)) ? cnt_ff - CNT_W'(8) : '0;
               end
            end else begin
               state_in = P_END;
            end
         end
         P_END: begin
            if (!hold_v_ff) begin
               state_in = P_IDLE;
            end else if (out_free) begin
               out_v_in    = 1'b1;
               out_in      = hold_ff;
               out_last_in = 1'b1;
               out_end_in  = end_ff;
               hold_v_in   = 1'b0;
               state_in    = P_IDLE;
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase

      if (produce) begin
         if (hold_v_ff) begin
            out_v_in    = 1'b1;
            out_in      = hold_ff;
            out_last_in = 1'b0;
            out_end_in  = 1'b0;
         end
         hold_v_in = 1'b1;
         hold_in   = buf_ff[7:0];
         buf_in    = buf_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      end_ff      <= end_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
      if (reset) begin
         state_ff  <= P_IDLE;
         cnt_ff    <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

endmodule

>>> rtl/gif_lzw_encoder.sv
// top level of the gif lzw encoder
//
// req channel: one pixel per transfer, tuser marks the first pixel of an
// image, tlast the final one. pixels outside an image are dropped.
// rsp channel: packed lsb-first code stream bytes. tlast marks the last
// byte caused by one pixel, tuser the final byte of the image stream.
// a pixel is popped, probed in the hash table (table read, then compare,
// per probe) and its mark then handed to the bit packer; a code handed
// to the packer keeps it busy until its full bytes are out. the engine
// pops no new pixel before it has handed over the last one's mark;
// the probe loop over the single table port sets the pixel rate.
// after reset, a first pixel, a full dictionary or a probe that finds no
// free slot the hash table is swept clear, one entry per cycle over all
// HASH_SIZE entries; meanwhile pixels wait in the input queue unprobed.
// a stalled receiver holds the output byte; one more byte waits in the
// hold register, then the packer, the engine and finally the input queue
// fill and req_tready drops.
module gif_lzw_encoder
   import glzw_pkg::*;
#(
   parameter int HASH_SIZE     = HASH_SIZE_DEF,
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // pixel
   input  logic       req_tlast,
   input  logic       req_tuser,   // first_pixel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // image_end
);

   logic            push_valid, push_ready;
   item_type        push_item;
   logic            pop_valid, pop_ready;
   item_type        pop_item;
   logic            cmd_valid, cmd_ready;
   cmd_type         cmd;
   core_status_type status;

   glzw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   glzw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   glzw_core #(
      .HASH_SIZE     (HASH_SIZE),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .status    (status)
   );

   glzw_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_no_probe_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !(status.sweeping && status.probing))
      else $error("hash probe during table sweep");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("image end byte not marked last");

   a_cmd_holds: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
      else $error("packer command changed while stalled");
`endif

endmodule
